FILE: rtl/vne_pkg.sv
// Shared types, constants and neighbour offset tables for the voxel neighbour enumerator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package vne_pkg;

  localparam int CoordW = 10;
  localparam int SizeW = 11;
  localparam int ModeW = 2;
  localparam int NumCand = 12;
  localparam int CandIdxW = 4;
  localparam int CfgIdxW = 2;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW = 2;
  localparam int QueueCntW = 3;

  localparam logic [SizeW-1:0] GRID_DIM_MAX = 11'd1024;
  localparam logic [SizeW-1:0] GRID_SIZE_RESET = 11'd1024;

  localparam logic [ModeW-1:0] MODE_FACE = 2'd0;
  localparam logic [ModeW-1:0] MODE_EDGE = 2'd1;
  localparam logic [ModeW-1:0] MODE_CORNER = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_GRID_SIZE_X = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_GRID_SIZE_Y = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_GRID_SIZE_Z = 2'd2;

  localparam logic signed [1:0] OFS_NEG = -2'sd1;
  localparam logic signed [1:0] OFS_ZERO = 2'sd0;
  localparam logic signed [1:0] OFS_POS = 2'sd1;

  typedef struct packed {
    logic used;
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic signed [1:0] dz;
  } offset_t;

  typedef struct packed {
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [CoordW-1:0] cz;
    logic [ModeW-1:0] mode;
    logic [NumCand-1:0] mask;
  } cell_entry_t;

  typedef struct packed {
    logic lo_ok;
    logic mid_ok;
    logic hi_ok;
  } axis_ok_t;

  function automatic offset_t mk(input logic signed [1:0] dx, input logic signed [1:0] dy,
                                 input logic signed [1:0] dz);
    offset_t o;
    o.used = 1'b1;
    o.dx = dx;
    o.dy = dy;
    o.dz = dz;
    return o;
  endfunction

  function automatic offset_t nbr_offset(input logic [ModeW-1:0] mode,
                                         input logic [CandIdxW-1:0] idx);
    offset_t o;
    o = '0;
    case (mode)
      MODE_FACE: begin
        case (idx)
          4'd0: o = mk(OFS_NEG, OFS_ZERO, OFS_ZERO);
          4'd1: o = mk(OFS_POS, OFS_ZERO, OFS_ZERO);
          4'd2: o = mk(OFS_ZERO, OFS_NEG, OFS_ZERO);
          4'd3: o = mk(OFS_ZERO, OFS_POS, OFS_ZERO);
          4'd4: o = mk(OFS_ZERO, OFS_ZERO, OFS_NEG);
          4'd5: o = mk(OFS_ZERO, OFS_ZERO, OFS_POS);
          default: o = '0;
        endcase
      end
      MODE_EDGE: begin
        case (idx)
          4'd0: o = mk(OFS_NEG, OFS_ZERO, OFS_NEG);
          4'd1: o = mk(OFS_POS, OFS_ZERO, OFS_NEG);
          4'd2: o = mk(OFS_POS, OFS_ZERO, OFS_POS);
          4'd3: o = mk(OFS_NEG, OFS_ZERO, OFS_POS);
          4'd4: o = mk(OFS_NEG, OFS_POS, OFS_ZERO);
          4'd5: o = mk(OFS_NEG, OFS_NEG, OFS_ZERO);
          4'd6: o = mk(OFS_POS, OFS_NEG, OFS_ZERO);
          4'd7: o = mk(OFS_POS, OFS_POS, OFS_ZERO);
          4'd8: o = mk(OFS_ZERO, OFS_POS, OFS_POS);
          4'd9: o = mk(OFS_ZERO, OFS_POS, OFS_NEG);
          4'd10: o = mk(OFS_ZERO, OFS_NEG, OFS_NEG);
          4'd11: o = mk(OFS_ZERO, OFS_NEG, OFS_POS);
          default: o = '0;
        endcase
      end
      MODE_CORNER: begin
        case (idx)
          4'd0: o = mk(OFS_POS, OFS_POS, OFS_POS);
          4'd1: o = mk(OFS_POS, OFS_NEG, OFS_POS);
          4'd2: o = mk(OFS_NEG, OFS_NEG, OFS_POS);
          4'd3: o = mk(OFS_NEG, OFS_POS, OFS_POS);
          4'd4: o = mk(OFS_POS, OFS_POS, OFS_NEG);
          4'd5: o = mk(OFS_POS, OFS_NEG, OFS_NEG);
          4'd6: o = mk(OFS_NEG, OFS_NEG, OFS_NEG);
          4'd7: o = mk(OFS_NEG, OFS_POS, OFS_NEG);
          default: o = '0;
        endcase
      end
      default: o = '0;
    endcase
    return o;
  endfunction

  function automatic logic axis_pick(input axis_ok_t a, input logic signed [1:0] d);
    logic r;
    r = 1'b0;
    case (d)
      OFS_NEG: r = a.lo_ok;
      OFS_ZERO: r = a.mid_ok;
      OFS_POS: r = a.hi_ok;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [CoordW-1:0] add_ofs(input logic [CoordW-1:0] c,
                                                input logic signed [1:0] d);
    return c + {{(CoordW-2){d[1]}}, d};
  endfunction

endpackage

FILE: rtl/vne_front.sv
// Front end: takes input words, checks every candidate against the grid and builds its mask.
// Depends on vne_pkg.
`timescale 1ns / 1ps

module vne_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [vne_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [vne_pkg::SizeW-1:0]       cfg_data,
  input  logic [vne_pkg::CoordW-1:0]      center_x,
  input  logic [vne_pkg::CoordW-1:0]      center_y,
  input  logic [vne_pkg::CoordW-1:0]      center_z,
  input  logic [vne_pkg::ModeW-1:0]       mode,
  output vne_pkg::cell_entry_t            entry
);

  logic [vne_pkg::SizeW-1:0] grid_size_x;
  logic [vne_pkg::SizeW-1:0] grid_size_y;
  logic [vne_pkg::SizeW-1:0] grid_size_z;
  logic [vne_pkg::SizeW-1:0] sx;
  logic [vne_pkg::SizeW-1:0] sy;
  logic [vne_pkg::SizeW-1:0] sz;
  vne_pkg::axis_ok_t ax;
  vne_pkg::axis_ok_t ay;
  vne_pkg::axis_ok_t az;
  vne_pkg::offset_t ofs [vne_pkg::NumCand];

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size_x <= vne_pkg::GRID_SIZE_RESET;
      grid_size_y <= vne_pkg::GRID_SIZE_RESET;
      grid_size_z <= vne_pkg::GRID_SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        vne_pkg::REG_GRID_SIZE_X: grid_size_x <= cfg_data;
        vne_pkg::REG_GRID_SIZE_Y: grid_size_y <= cfg_data;
        vne_pkg::REG_GRID_SIZE_Z: grid_size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [vne_pkg::SizeW-1:0] sat(input logic [vne_pkg::SizeW-1:0] s);
    return (s > vne_pkg::GRID_DIM_MAX) ? vne_pkg::GRID_DIM_MAX : s;
  endfunction

  function automatic vne_pkg::axis_ok_t axis_check(input logic [vne_pkg::CoordW-1:0] c,
                                                   input logic [vne_pkg::SizeW-1:0] s);
    vne_pkg::axis_ok_t a;
    logic [vne_pkg::SizeW-1:0] cw;
    cw = {1'b0, c};
    a.lo_ok = (c != '0) && (cw <= s);
    a.mid_ok = cw < s;
    a.hi_ok = (cw + 1'b1) < s;
    return a;
  endfunction

  always_comb begin
    sx = sat(grid_size_x);
    sy = sat(grid_size_y);
    sz = sat(grid_size_z);
    ax = axis_check(center_x, sx);
    ay = axis_check(center_y, sy);
    az = axis_check(center_z, sz);
    entry.cx = center_x;
    entry.cy = center_y;
    entry.cz = center_z;
    entry.mode = mode;
    for (int i = 0; i < vne_pkg::NumCand; i++) begin
      ofs[i] = vne_pkg::nbr_offset(mode, vne_pkg::CandIdxW'(i));
      entry.mask[i] = ofs[i].used && vne_pkg::axis_pick(ax, ofs[i].dx)
                      && vne_pkg::axis_pick(ay, ofs[i].dy)
                      && vne_pkg::axis_pick(az, ofs[i].dz);
    end
  end

endmodule

FILE: rtl/vne_queue.sv
// Short queue of classified cells between the front end and the back end.
// Depends on vne_pkg.
`timescale 1ns / 1ps

module vne_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  vne_pkg::cell_entry_t push_entry,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output vne_pkg::cell_entry_t head
);

  vne_pkg::cell_entry_t mem [vne_pkg::QueueDepth];
  logic [vne_pkg::QueuePtrW-1:0] wr_ptr;
  logic [vne_pkg::QueuePtrW-1:0] rd_ptr;
  logic [vne_pkg::QueueCntW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = count == vne_pkg::QueueCntW'(vne_pkg::QueueDepth);
  assign not_empty = count != '0;
  assign do_push = push && !full;
  assign do_pop = pop && not_empty;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/vne_back.sv
// Back end: walks the candidate mask of the queue head and sends one neighbour word a cycle while out_stall is low.
// Depends on vne_pkg.
`timescale 1ns / 1ps

module vne_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  vne_pkg::cell_entry_t        head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [vne_pkg::CoordW-1:0]  neighbour_x,
  output logic [vne_pkg::CoordW-1:0]  neighbour_y,
  output logic [vne_pkg::CoordW-1:0]  neighbour_z,
  output logic                        found,
  output logic                        last
);

  logic [vne_pkg::NumCand-1:0] done;
  logic [vne_pkg::NumCand-1:0] pend;
  logic [vne_pkg::NumCand-1:0] sel_hot;
  logic [vne_pkg::CandIdxW-1:0] sel;
  logic load;
  logic emit;
  logic is_last;
  vne_pkg::offset_t ofs;

  always_comb begin
    pend = head.mask & ~done;
    sel = '0;
    for (int i = vne_pkg::NumCand - 1; i >= 0; i--) begin
      if (pend[i]) begin
        sel = vne_pkg::CandIdxW'(i);
      end
    end
    sel_hot = vne_pkg::NumCand'(1) << sel;
    is_last = (pend & ~sel_hot) == '0;
    ofs = vne_pkg::nbr_offset(head.mode, sel);
    load = !out_valid || !out_stall;
    emit = load && head_valid;
    pop = emit && is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done <= '0;
    end else if (load) begin
      out_valid <= head_valid;
      if (emit) begin
        done <= is_last ? '0 : (done | sel_hot);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      last <= is_last;
      if (pend == '0) begin
        neighbour_x <= '0;
        neighbour_y <= '0;
        neighbour_z <= '0;
        found <= 1'b0;
      end else begin
        neighbour_x <= vne_pkg::add_ofs(head.cx, ofs.dx);
        neighbour_y <= vne_pkg::add_ofs(head.cy, ofs.dy);
        neighbour_z <= vne_pkg::add_ofs(head.cz, ofs.dz);
        found <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/voxel_neighbour_enumerator.sv
// Top level of the voxel neighbour enumerator: front end, cell queue and back end.
// Depends on vne_pkg, vne_front, vne_queue and vne_back.
`timescale 1ns / 1ps

// Each input word names a centre cell and a neighbour kind (face, edge or corner). The block
// sends the neighbours that lie inside the configured grid, in table order, one word per cycle
// while out_stall is low, with last set on the final one; when none is inside, a single word
// with found low and last high is sent. An item gives as many output words as it has
// neighbours inside the grid, between 1 and 12, and the output stage sets the throughput.
// Input words are taken one per cycle while the four-entry queue between the grid check and
// the output stage has room; the first result word of an input is registered in the queue
// and then in the output register before it is valid on the output.

module voxel_neighbour_enumerator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [vne_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [vne_pkg::SizeW-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [vne_pkg::CoordW-1:0]  center_x,
  input  logic [vne_pkg::CoordW-1:0]  center_y,
  input  logic [vne_pkg::CoordW-1:0]  center_z,
  input  logic [vne_pkg::ModeW-1:0]   mode,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [vne_pkg::CoordW-1:0]  neighbour_x,
  output logic [vne_pkg::CoordW-1:0]  neighbour_y,
  output logic [vne_pkg::CoordW-1:0]  neighbour_z,
  output logic                        found,
  output logic                        last
);

  vne_pkg::cell_entry_t entry;
  vne_pkg::cell_entry_t head;
  logic full;
  logic not_empty;
  logic pop;

  assign in_stall = full;

  vne_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .center_x (center_x),
    .center_y (center_y),
    .center_z (center_z),
    .mode     (mode),
    .entry    (entry)
  );

  vne_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_entry(entry),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  vne_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (not_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .neighbour_x(neighbour_x),
    .neighbour_y(neighbour_y),
    .neighbour_z(neighbour_z),
    .found      (found),
    .last       (last)
  );

endmodule
